// ===== hdl/sac_pkg.sv =====
`timescale 1ns / 1ps

package sac_pkg;

	localparam int COORD_BITS    = 16;
	localparam int COS_FRAC_BITS = 14;
	localparam int COS_BITS      = COS_FRAC_BITS + 2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_x_start;
		logic signed [COORD_BITS-1:0] a_y_start;
		logic signed [COORD_BITS-1:0] a_x_end;
		logic signed [COORD_BITS-1:0] a_y_end;
		logic signed [COORD_BITS-1:0] b_x_start;
		logic signed [COORD_BITS-1:0] b_y_start;
		logic signed [COORD_BITS-1:0] b_x_end;
		logic signed [COORD_BITS-1:0] b_y_end;
	} seg_word_t;

	typedef struct packed {
		logic signed [COS_BITS-1:0] cosine;
		logic                       degenerate;
	} cos_word_t;

endpackage

// ===== hdl/segment_angle_cosine.sv =====
`timescale 1ns / 1ps

// Pipeline: s1, s2, s3, the root-search stages and the output register lie between start and result strobe.
// Throughput: one word per cycle; busy is always low.
// The root search is one restoring square-root stage per result bit.
// arst_n clears all valid bits; results cannot be stalled by the receiver.
module segment_angle_cosine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sac_pkg::seg_word_t  seg,
	output logic                result_valid,
	output sac_pkg::cos_word_t  result
);

	localparam int C  = sac_pkg::COORD_BITS;
	localparam int F  = sac_pkg::COS_FRAC_BITS;
	localparam int D  = C + 1;
	localparam int LW = 2 * C + 2;
	localparam int PW = 2 * LW + 2 * F + 4;
	localparam int NS = F + 1;

	assign busy = 1'b0;

	// s1: direction vectors
	logic                v_s1;
	logic signed [D-1:0] ax_s1, ay_s1, bx_s1, by_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= D'(seg.a_x_end) - D'(seg.a_x_start);
		ay_s1 <= D'(seg.a_y_end) - D'(seg.a_y_start);
		bx_s1 <= D'(seg.b_x_end) - D'(seg.b_x_start);
		by_s1 <= D'(seg.b_y_end) - D'(seg.b_y_start);
	end

	// s2: squared lengths and dot product
	logic                 v_s2;
	logic [LW-1:0]        la2_s2, lb2_s2;
	logic signed [LW-1:0] dot_s2;
	logic signed [LW-1:0] axx, ayy, bxx, byy, axbx, ayby;

	assign axx  = ax_s1 * ax_s1;
	assign ayy  = ay_s1 * ay_s1;
	assign bxx  = bx_s1 * bx_s1;
	assign byy  = by_s1 * by_s1;
	assign axbx = ax_s1 * bx_s1;
	assign ayby = ay_s1 * by_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		la2_s2 <= unsigned'(axx) + unsigned'(ayy);
		lb2_s2 <= unsigned'(bxx) + unsigned'(byy);
		dot_s2 <= axbx + ayby;
	end

	// s3: length product, squared dot magnitude
	logic                v_s3, deg_s3, neg_s3;
	logic [2*LW-1:0]     len2_s3, mag2_s3;
	logic [LW-1:0]       mag;

	assign mag = dot_s2[LW-1] ? LW'(-dot_s2) : LW'(dot_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		deg_s3  <= (la2_s2 == '0) || (lb2_s2 == '0);
		neg_s3  <= dot_s2[LW-1];
		len2_s3 <= la2_s2 * lb2_s2;
		mag2_s3 <= mag * mag;
	end

	// root search: find largest q with q*q*len2 <= mag2 << 2F
	logic          v_sn   [0:NS];
	logic          deg_sn [0:NS];
	logic          neg_sn [0:NS];
	logic [PW-1:0] l_sn   [0:NS];
	logic [PW-1:0] r_sn   [0:NS];
	logic [PW-1:0] p_sn   [0:NS];
	logic [PW-1:0] qq_sn  [0:NS];
	logic [F:0]    q_sn   [0:NS];

	always_comb begin
		v_sn[0]   = v_s3;
		deg_sn[0] = deg_s3;
		neg_sn[0] = neg_s3;
		l_sn[0]   = PW'(len2_s3);
		r_sn[0]   = PW'(mag2_s3) << (2 * F);
		p_sn[0]   = '0;
		qq_sn[0]  = '0;
		q_sn[0]   = '0;
	end

	for (genvar i = 0; i < NS; i++) begin : g_root
		localparam int K = F - i;
		logic [PW-1:0] cand;
		assign cand = p_sn[i] + (qq_sn[i] << (K + 1)) + (l_sn[i] << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[i+1] <= 1'b0;
			end else begin
				v_sn[i+1] <= v_sn[i];
			end
		end

		always_ff @(posedge clk) begin
			deg_sn[i+1] <= deg_sn[i];
			neg_sn[i+1] <= neg_sn[i];
			l_sn[i+1]   <= l_sn[i];
			r_sn[i+1]   <= r_sn[i];
			if (cand <= r_sn[i]) begin
				p_sn[i+1]  <= cand;
				qq_sn[i+1] <= qq_sn[i] + (l_sn[i] << K);
				q_sn[i+1]  <= q_sn[i] | ((F+1)'(1) << K);
			end else begin
				p_sn[i+1]  <= p_sn[i];
				qq_sn[i+1] <= qq_sn[i];
				q_sn[i+1]  <= q_sn[i];
			end
		end
	end

	// output register: clamp, sign
	logic [F:0] one, lo;
	assign one = (F+1)'(1) << F;
	assign lo  = (q_sn[NS] > one) ? one : q_sn[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= v_sn[NS];
		end
	end

	always_ff @(posedge clk) begin
		result.degenerate <= deg_sn[NS];
		if (deg_sn[NS]) begin
			result.cosine <= '0;
		end else if (neg_sn[NS]) begin
			result.cosine <= -$signed({1'b0, lo});
		end else begin
			result.cosine <= $signed({1'b0, lo});
		end
	end

endmodule
